// File: rtl/owbm_pkg.sv
// ----------------------------------------------------------------------------
// owbm_pkg - shared types and timing constants
// Phase codes, command codes and microsecond timing of the one-wire master.
// ----------------------------------------------------------------------------
package owbm_pkg;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_RESET = 2'd1,
    PH_WRITE = 2'd2,
    PH_READ  = 2'd3
  } phase_t;

  localparam logic [1:0] REQ_NONE  = 2'd0;
  localparam logic [1:0] REQ_RESET = 2'd1;
  localparam logic [1:0] REQ_WRITE = 2'd2;
  localparam logic [1:0] REQ_READ  = 2'd3;

  localparam int TIMER_W = 10;

  // Tick offsets inside a sequence or a slot
  localparam logic [TIMER_W-1:0] RST_LOW    = 10'd480;
  localparam logic [TIMER_W-1:0] RST_SAMPLE = 10'd550;  // 480 + 70
  localparam logic [TIMER_W-1:0] RST_LAST   = 10'd959;  // 480 + 70 + 410 - 1
  localparam logic [TIMER_W-1:0] W1_LOW     = 10'd6;
  localparam logic [TIMER_W-1:0] W0_LOW     = 10'd60;
  localparam logic [TIMER_W-1:0] RD_LOW     = 10'd6;
  localparam logic [TIMER_W-1:0] RD_SAMPLE  = 10'd15;   // 6 + 9
  localparam logic [TIMER_W-1:0] SLOT_LAST  = 10'd69;   // 6 + 64 - 1

  localparam logic [2:0] BIT_LAST = 3'd7;

  typedef struct packed {
    phase_t               phase;
    logic [TIMER_W-1:0]   timer;
    logic [2:0]           bit_idx;
    logic [7:0]           shift;
    logic                 pres;
    logic [7:0]           rdata;
  } seq_state_t;

  typedef struct packed {
    logic drive;
    logic busy;
    logic done;
    logic rej;
  } tick_res_t;

endpackage

// File: rtl/owbm_seq.sv
// ----------------------------------------------------------------------------
// owbm_seq - one-tick sequencer step
// Combinational step of the bus sequencer: takes the current state and one
// tick request, gives the next state and the tick's line and status bits.
// ----------------------------------------------------------------------------
module owbm_seq
  import owbm_pkg::*;
(
  input  seq_state_t  cur,
  input  logic [1:0]  req_type,
  input  logic [7:0]  write_data,
  input  logic        bus_level,
  output seq_state_t  nxt,
  output tick_res_t   res
);

  seq_state_t eff;
  logic       start;

  // Command start folds into the same tick: tick 0 of the new sequence.
  always_comb begin
    start = (req_type != REQ_NONE) && (cur.phase == PH_IDLE);
    eff   = cur;
    if (start) begin
      eff.timer   = '0;
      eff.bit_idx = '0;
      case (req_type)
        REQ_RESET: begin
          eff.phase = PH_RESET;
          eff.pres  = 1'b0;
        end
        REQ_WRITE: begin
          eff.phase = PH_WRITE;
          eff.shift = write_data;
        end
        REQ_READ: begin
          eff.phase = PH_READ;
          eff.shift = '0;
        end
        default: eff.phase = PH_IDLE;
      endcase
    end
  end

  // Next state
  always_comb begin
    logic [7:0] sh;
    sh  = eff.shift;
    nxt = eff;
    case (eff.phase)
      PH_RESET: begin
        if (eff.timer == RST_SAMPLE) nxt.pres = ~bus_level;
        if (eff.timer >= RST_LAST) begin
          nxt.phase = PH_IDLE;
          nxt.timer = '0;
        end else begin
          nxt.timer = TIMER_W'(eff.timer + 1'b1);
        end
      end
      PH_WRITE, PH_READ: begin
        if (eff.phase == PH_READ && eff.timer == RD_SAMPLE) sh = {bus_level, sh[7:1]};
        if (eff.timer >= SLOT_LAST) begin
          if (eff.phase == PH_WRITE) sh = {1'b0, sh[7:1]};
          nxt.timer = '0;
          if (eff.bit_idx == BIT_LAST) begin
            if (eff.phase == PH_READ) nxt.rdata = sh;
            nxt.phase   = PH_IDLE;
            nxt.bit_idx = '0;
          end else begin
            nxt.bit_idx = 3'(eff.bit_idx + 1'b1);
          end
        end else begin
          nxt.timer = TIMER_W'(eff.timer + 1'b1);
        end
        nxt.shift = sh;
      end
      default: nxt = eff;
    endcase
  end

  // Tick outputs
  always_comb begin
    res      = '0;
    res.rej  = (req_type != REQ_NONE) && !start;
    res.busy = (eff.phase != PH_IDLE);
    case (eff.phase)
      PH_RESET: begin
        res.drive = (eff.timer < RST_LOW);
        res.done  = (eff.timer >= RST_LAST);
      end
      PH_WRITE: begin
        res.drive = (eff.timer < (eff.shift[0] ? W1_LOW : W0_LOW));
        res.done  = (eff.timer >= SLOT_LAST) && (eff.bit_idx == BIT_LAST);
      end
      PH_READ: begin
        res.drive = (eff.timer < RD_LOW);
        res.done  = (eff.timer >= SLOT_LAST) && (eff.bit_idx == BIT_LAST);
      end
      default: begin
        res.drive = 1'b0;
        res.done  = 1'b0;
      end
    endcase
  end

endmodule

// File: rtl/one_wire_bus_master.sv
// ----------------------------------------------------------------------------
// one_wire_bus_master - tick-driven one-wire bus master
// Each input request is one microsecond tick carrying an optional command
// (reset pulse, write byte, read byte) and the sampled line level. Each
// tick yields exactly one result: line drive, busy, done, presence, read
// byte and a command-rejected flag.
//
// Channels: in_* and out_* are valid/ready. A request moves at an edge with
// valid and ready both high. The request lands in the input register, then
// one combinational sequencer step writes the output register and the
// sequencer state. Throughput is one tick per cycle while out_ready is high;
// the input register and the output register let a new request enter while
// a result waits. When out_ready is low the output holds, the input register
// fills, and in_ready drops until the output drains.
// Reset (rst_n low, synchronous) empties both registers and returns the
// sequencer to idle with presence and read byte cleared.
// Timing: reset is 960 ticks, write and read are 8 slots of 70 ticks.
// ----------------------------------------------------------------------------
module one_wire_bus_master
  import owbm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [7:0]  in_write_data,
  input  logic        in_bus_level,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_drive_low,
  output logic        out_busy_res,
  output logic        out_done_res,
  output logic        out_presence,
  output logic [7:0]  out_read_data,
  output logic        out_cmd_rejected
);

  // input register
  logic        s1_valid_r;
  logic [1:0]  s1_req_r;
  logic [7:0]  s1_wdata_r;
  logic        s1_level_r;

  // sequencer state
  seq_state_t  state_r;
  seq_state_t  state_nxt;
  tick_res_t   res;

  // output register
  logic        out_valid_r;
  tick_res_t   out_res_r;
  logic        out_pres_r;
  logic [7:0]  out_rdata_r;

  logic        s1_adv;   // input register may move into the output register
  logic        step;     // a tick is processed this cycle

  assign s1_adv   = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s1_adv;
  assign step     = s1_valid_r && s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_req_r   <= in_req_type;
      s1_wdata_r <= in_write_data;
      s1_level_r <= in_bus_level;
    end
  end

  owbm_seq u_seq (
    .cur        (state_r),
    .req_type   (s1_req_r),
    .write_data (s1_wdata_r),
    .bus_level  (s1_level_r),
    .nxt        (state_nxt),
    .res        (res)
  );

  // Sequencer state advances only when the tick's result is taken in.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{phase: PH_IDLE, timer: '0, bit_idx: '0, shift: '0,
                   pres: 1'b0, rdata: '0};
    end else if (step) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res_r   <= res;
      out_pres_r  <= state_nxt.pres;
      out_rdata_r <= state_nxt.rdata;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_drive_low    = out_res_r.drive;
  assign out_busy_res     = out_res_r.busy;
  assign out_done_res     = out_res_r.done;
  assign out_presence     = out_pres_r;
  assign out_read_data    = out_rdata_r;
  assign out_cmd_rejected = out_res_r.rej;

  // ---------------------------------------------------------------- checks
  a_done_idles: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res.done) |=> (state_r.phase == PH_IDLE))
    else $error("sequence completed but phase not idle");

  a_timer_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.timer <= RST_LAST))
    else $error("slot timer out of range");

  a_drive_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!(out_drive_low || out_done_res) || out_busy_res))
    else $error("line driven or done while not busy");

  a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res.rej) |-> (state_r.phase != PH_IDLE))
    else $error("command rejected while idle");

  a_hold_state: assert property (@(posedge clk) disable iff (!rst_n)
    (!step) |=> $stable(state_r))
    else $error("sequencer state moved without a tick");

endmodule
